// ===== rtl/rau_pkg.sv =====
// Package for the rational arithmetic unit: payload types, codes, constants.
package rau_pkg;

  localparam int unsigned RAU_WIDTH = 32;

  typedef enum logic [2:0] {
    FN_ADD = 3'd0,
    FN_SUB = 3'd1,
    FN_MUL = 3'd2,
    FN_DIV = 3'd3,
    FN_EQ  = 3'd4
  } rau_func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_DIVZERO  = 2'd1,
    ST_OVERFLOW = 2'd2
  } rau_status_t;

  typedef struct packed {
    logic [2:0]         func;
    logic signed [31:0] a_num;
    logic [30:0]        a_den;
    logic signed [31:0] b_num;
    logic [30:0]        b_den;
  } rau_in_t;

  typedef struct packed {
    logic signed [31:0] res_num;
    logic [30:0]        res_den;
    logic               is_equal;
    logic [1:0]         status;
  } rau_out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_FORM,
    S_GCD_INIT,
    S_REM,
    S_GCD_NEXT,
    S_DIVN,
    S_DIVD,
    S_DONE
  } rau_state_t;

endpackage

// ===== rtl/rational_arithmetic_unit.sv =====
// Top level of the rational arithmetic unit: sequencer around one shared
// multiplier and one shared shift-subtract divider.
//
// Usage: drive in_data and raise start while busy is low; the item transfers
// at that edge and busy rises. Operand fields use their low WIDTH (numerator)
// and WIDTH-1 (denominator) bits. One result comes back on out_data with
// out_valid high for one cycle; the receiver cannot stall and must take it.
// Sequence: the shared multiplier forms the cross products, then the Euclidean
// gcd runs on magnitudes of up to 2*WIDTH bits, each remainder computed by a
// 1-bit-per-cycle restoring divider, then two such divisions reduce the
// numerator and denominator by the gcd. The gcd takes k remainder steps;
// k is at least one and reaches about 93 for Fibonacci-like operands.
// A zero result denominator skips the gcd and the divisions and goes straight
// to the result strobe.
// busy is high for the whole item; the next start is taken the cycle after
// out_valid.
// Reset (rst_n low, synchronous) returns the sequencer to idle and drops busy
// and out_valid; no item in flight survives reset.
module rational_arithmetic_unit #(
  parameter int unsigned WIDTH = rau_pkg::RAU_WIDTH
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  rau_pkg::rau_in_t  in_data,
  output logic              out_valid,
  output rau_pkg::rau_out_t out_data
);
  import rau_pkg::*;

  localparam int unsigned DW = 2 * WIDTH + 1; // signed double-width work value
  localparam int unsigned MW = 2 * WIDTH;     // magnitude width
  localparam int unsigned CW = $clog2(MW + 1);

  rau_state_t state_r, state_nxt;

  logic [2:0]              func_r;
  logic signed [WIDTH-1:0] an_r, bn_r;
  logic [WIDTH-2:0]        ad_r, bd_r;
  logic [1:0]              mstep_r;
  logic signed [DW-1:0]    p_r, q_r, nn_r, dd_r;
  logic signed [DW-1:0]    prod;
  logic                    eq_r, neg_r;
  logic [MW-1:0]           gx_r, gy_r, mag_r, dm_r;
  // divider
  logic [MW-1:0]           dvq_r, dvr_r, dvd_r;
  logic [CW-1:0]           cnt_r;
  logic [MW:0]             trial;
  logic                    div_done;
  rau_out_t                res_r;

  // shared multiplier operand select
  logic signed [WIDTH:0] mx, my;
  always_comb begin
    case (mstep_r)
      2'd0:    begin mx = {an_r[WIDTH-1], an_r}; my = {2'b00, bd_r}; end
      2'd1:    begin mx = {bn_r[WIDTH-1], bn_r}; my = {2'b00, ad_r}; end
      2'd2:    begin mx = {an_r[WIDTH-1], an_r}; my = {bn_r[WIDTH-1], bn_r}; end
      default: begin mx = {2'b00, ad_r}; my = {2'b00, bd_r}; end
    endcase
    prod = DW'(mx) * DW'(my);
  end

  assign trial    = {dvr_r, dvq_r[MW-1]} - {1'b0, dvd_r};
  assign div_done = (cnt_r == CW'(MW));

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (start) state_nxt = S_MUL;
      S_MUL:      if (mstep_r == 2'd3) state_nxt = S_FORM;
      S_FORM:     state_nxt = (dd_r == '0) ? S_DONE : S_GCD_INIT;
      S_GCD_INIT: state_nxt = (gy_r == '0) ? S_DIVN : S_REM;
      S_REM:      if (div_done) state_nxt = S_GCD_NEXT;
      S_GCD_NEXT: state_nxt = (dvr_r == '0) ? S_DIVN : S_REM;
      S_DIVN:     if (div_done) state_nxt = S_DIVD;
      S_DIVD:     if (div_done) state_nxt = S_DONE;
      S_DONE:     state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    out_data  = res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  logic signed [DW-1:0] dd_abs_num, dd_abs_den;
  always_comb begin
    dd_abs_num = dd_r[DW-1] ? -nn_r : nn_r;
    dd_abs_den = dd_r[DW-1] ? -dd_r : dd_r;
  end

  // final packing from the reduced numerator and the quotient of the last division
  logic [MW-1:0] fin_den;
  logic          fin_ovf;
  always_comb begin
    fin_den = (mag_r == '0) ? MW'(1) : dvq_r;
    fin_ovf = (fin_den > MW'((64'd1 << (WIDTH-1)) - 1)) ||
              (neg_r && mag_r > MW'(64'd1 << (WIDTH-1))) ||
              (!neg_r && mag_r > MW'((64'd1 << (WIDTH-1)) - 1));
  end

  rau_out_t res_fin;
  always_comb begin
    res_fin          = res_r;
    res_fin.status   = fin_ovf ? ST_OVERFLOW : ST_OK;
    res_fin.res_num  = fin_ovf ? '0 :
                       32'($signed(neg_r ? -WIDTH'(mag_r) : WIDTH'(mag_r)));
    res_fin.res_den  = fin_ovf ? 31'd1 : 31'(fin_den);
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: if (start) begin
        func_r  <= in_data.func;
        an_r    <= in_data.a_num[WIDTH-1:0];
        bn_r    <= in_data.b_num[WIDTH-1:0];
        ad_r    <= in_data.a_den[WIDTH-2:0];
        bd_r    <= in_data.b_den[WIDTH-2:0];
        mstep_r <= 2'd0;
      end
      S_MUL: begin
        mstep_r <= mstep_r + 2'd1;
        case (mstep_r)
          2'd0:    p_r <= prod;
          2'd1:    q_r <= prod;
          2'd2:    nn_r <= prod;
          default: begin
            eq_r <= (ad_r != '0) && (bd_r != '0) && (p_r == q_r);
            case (func_r)
              FN_ADD: begin nn_r <= p_r + q_r; dd_r <= prod; end
              FN_SUB: begin nn_r <= p_r - q_r; dd_r <= prod; end
              FN_MUL: dd_r <= prod;
              // quotient denominator is bn*ad, already held as q
              FN_DIV: begin nn_r <= p_r; dd_r <= q_r; end
              FN_EQ: begin
                nn_r <= '0;
                dd_r <= DW'((ad_r != '0) && (bd_r != '0));
              end
              default: begin nn_r <= '0; dd_r <= DW'(1); end
            endcase
          end
        endcase
      end
      S_FORM: begin
        res_r <= '{res_num: '0, res_den: 31'd1, is_equal: eq_r, status: ST_DIVZERO};
        neg_r <= dd_abs_num[DW-1];
        mag_r <= MW'(dd_abs_num[DW-1] ? -dd_abs_num : dd_abs_num);
        dm_r  <= MW'(dd_abs_den);
        gx_r  <= MW'(dd_abs_num[DW-1] ? -dd_abs_num : dd_abs_num);
        gy_r  <= MW'(dd_abs_den);
      end
      S_GCD_INIT: begin
        if (gy_r == '0) begin
          dvq_r <= mag_r;
          dvd_r <= gx_r;
        end else begin
          dvq_r <= gx_r;
          dvd_r <= gy_r;
        end
        dvr_r <= '0;
        cnt_r <= '0;
      end
      S_GCD_NEXT: begin
        gx_r <= gy_r;
        gy_r <= dvr_r;
        if (dvr_r == '0) begin
          dvq_r <= mag_r;
          dvd_r <= gy_r;
        end else begin
          dvq_r <= gy_r;
          dvd_r <= dvr_r;
        end
        dvr_r <= '0;
        cnt_r <= '0;
      end
      S_REM, S_DIVN, S_DIVD: begin
        if (!div_done) begin
          cnt_r <= cnt_r + CW'(1);
          if (!trial[MW]) begin
            dvr_r <= trial[MW-1:0];
            dvq_r <= {dvq_r[MW-2:0], 1'b1};
          end else begin
            dvr_r <= {dvr_r[MW-2:0], dvq_r[MW-1]};
            dvq_r <= {dvq_r[MW-2:0], 1'b0};
          end
        end else if (state_r == S_DIVN) begin
          // hold the gcd in dvd_r, reduce the denominator next
          mag_r <= dvq_r;
          dvq_r <= dm_r;
          dvr_r <= '0;
          cnt_r <= '0;
        end else if (state_r == S_DIVD) begin
          dm_r  <= dvq_r;
          res_r <= res_fin;
        end
      end
      S_DONE: ;
      default: ;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");
  assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("transfer did not raise busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.status != 2'd3)) else $error("bad status code");
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.res_den == 31'd1))
    else $error("error result not 0/1");

endmodule
